@@ hw/rtl/mpfb_pkg.sv @@
// Shared types and constants of the page framebuffer rectangle engine.
package mpfb_pkg;

    // Panel geometry defaults and page organization
    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 64;
    localparam int ROWS_PER_PAGE    = 8;

    // Command queue depth between front and back
    localparam int CMD_DEPTH = 4;

    // Field widths of one input item
    localparam int ACT_W  = 2;
    localparam int X_W    = 8;
    localparam int Y_W    = 7;
    localparam int ADDR_W = 10;
    localparam int PAGE_W = Y_W - 3;
    localparam int DATA_W = 8;
    localparam int IN_TDATA_W = 48;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_OUTLINE = 2'd1,
        ACT_FILL    = 2'd2,
        ACT_READ    = 2'd3
    } action_t;

    // Classified command as queued for the back end
    typedef struct packed {
        action_t             action;
        logic [X_W-1:0]      x_lo;
        logic [X_W-1:0]      x_hi;
        logic [X_W-1:0]      x_last;
        logic [Y_W-1:0]      y_lo;
        logic [Y_W-1:0]      y_hi;
        logic [PAGE_W-1:0]   page_first;
        logic [PAGE_W-1:0]   page_last;
        logic                empty;
        logic [ADDR_W-1:0]   addr;
    } cmd_t;

endpackage

@@ hw/rtl/mono_page_framebuffer_rect_engine_top.sv @@
// Top level of the page framebuffer rectangle engine.
//
// Commands enter on the s_ channel: clear, outline or fill a rectangle given by
// two corners, or read one stored byte. Each command returns one item on the m_
// channel: the byte for a read, zero for a drawing command, in command order.
// The front end orders the corners and clips the walk to the panel; a four-entry
// queue holds commands for the back end, which owns the frame store.
// A drawing command visits each byte of its clipped column and page range with a
// pipelined read-modify-write, one byte per cycle.
// The frame store has a single read and a single write port.
// The front end accepts up to four commands ahead while the back end works.
// After reset the store is cleared one byte per cycle, all PANEL_WIDTH times the
// page count bytes, with s_tready low during that pass.
// When m_tready is low the result waits in the output register; the back end
// holds in its last state and the queue fills, after which s_tready drops.
module mono_page_framebuffer_rect_engine_top #(
    parameter int PANEL_WIDTH  = mpfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = mpfb_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // action[1:0], x_first[9:2], y_first[16:10], x_second[24:17], y_second[31:25],
    // read_address[41:32], zero pad [47:42]
    input  logic [mpfb_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_data[7:0]
    output logic [mpfb_pkg::DATA_W-1:0]       m_tdata
);

    logic            push, pop, fifo_full, fifo_not_empty, clearing;
    mpfb_pkg::cmd_t  push_cmd, head_cmd;

    mpfb_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_full (fifo_full),
        .clearing  (clearing),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    mpfb_cmd_fifo #(
        .DEPTH (mpfb_pkg::CMD_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head_cmd  (head_cmd)
    );

    mpfb_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (fifo_not_empty),
        .cmd_in    (head_cmd),
        .pop       (pop),
        .clearing  (clearing),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ hw/rtl/mpfb_front.sv @@
// Front end: accepts commands, orders corners, clips the byte walk to the panel.
module mpfb_front #(
    parameter int PANEL_WIDTH  = mpfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = mpfb_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // action, x_first, y_first, x_second, y_second, read_address (low bit up), zero pad
    input  logic [mpfb_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              fifo_full,
    input  logic                              clearing,
    output logic                              push,
    output mpfb_pkg::cmd_t                    push_cmd
);

    localparam int PAGE_COUNT =
        (PANEL_HEIGHT + mpfb_pkg::ROWS_PER_PAGE - 1) / mpfb_pkg::ROWS_PER_PAGE;
    localparam logic [mpfb_pkg::X_W-1:0]    X_MAX = mpfb_pkg::X_W'(PANEL_WIDTH - 1);
    localparam logic [mpfb_pkg::PAGE_W-1:0] P_MAX = mpfb_pkg::PAGE_W'(PAGE_COUNT - 1);
    localparam logic [mpfb_pkg::Y_W:0]      Y_LIM = (mpfb_pkg::Y_W + 1)'(PANEL_HEIGHT);

    mpfb_pkg::action_t             action;
    logic [mpfb_pkg::X_W-1:0]      x_first, x_second, x_lo, x_hi;
    logic [mpfb_pkg::Y_W-1:0]      y_first, y_second, y_lo, y_hi, y_end;
    logic [mpfb_pkg::ADDR_W-1:0]   read_address;
    logic [mpfb_pkg::X_W:0]        x_end;
    logic                          outline;

    // Unpack the item
    assign action       = mpfb_pkg::action_t'(s_tdata[1:0]);
    assign x_first      = s_tdata[9:2];
    assign y_first      = s_tdata[16:10];
    assign x_second     = s_tdata[24:17];
    assign y_second     = s_tdata[31:25];
    assign read_address = s_tdata[41:32];

    // Order the corners
    assign x_lo = (x_first > x_second) ? x_second : x_first;
    assign x_hi = (x_first > x_second) ? x_first : x_second;
    assign y_lo = (y_first > y_second) ? y_second : y_first;
    assign y_hi = (y_first > y_second) ? y_first : y_second;

    // Outline covers the closed range, clear and fill the half-open one
    assign outline = (action == mpfb_pkg::ACT_OUTLINE);
    assign x_end   = outline ? {1'b0, x_hi} : ({1'b0, x_hi} - 9'd1);
    assign y_end   = outline ? y_hi : (y_hi - 7'd1);

    always_comb
    begin
        push_cmd.action     = action;
        push_cmd.x_lo       = x_lo;
        push_cmd.x_hi       = x_hi;
        push_cmd.y_lo       = y_lo;
        push_cmd.y_hi       = y_hi;
        push_cmd.addr       = read_address;
        push_cmd.page_first = y_lo[mpfb_pkg::Y_W-1:3];
        push_cmd.x_last     = (x_end > {1'b0, X_MAX}) ? X_MAX : x_end[mpfb_pkg::X_W-1:0];
        push_cmd.page_last  = (y_end[mpfb_pkg::Y_W-1:3] > P_MAX) ? P_MAX
                                                                 : y_end[mpfb_pkg::Y_W-1:3];
        // Nothing on the panel to touch
        push_cmd.empty      = (x_lo > X_MAX) || ({1'b0, y_lo} >= Y_LIM) ||
                              (!outline && ((x_lo == x_hi) || (y_lo == y_hi)));
    end

    // Hold off during the clearing pass and while the queue is full
    assign s_tready = !fifo_full && !clearing;
    assign push     = s_tvalid && s_tready;

endmodule

@@ hw/rtl/mpfb_cmd_fifo.sv @@
// Short command queue between front and back end.
module mpfb_cmd_fifo #(
    parameter int DEPTH = mpfb_pkg::CMD_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mpfb_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output mpfb_pkg::cmd_t  head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mpfb_pkg::cmd_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // The back end only pops a queue that holds something
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("command queue popped while empty");

endmodule

@@ hw/rtl/mpfb_back.sv @@
// Back end: frame store, clearing pass, byte walk with read-modify-write, result register.
module mpfb_back #(
    parameter int PANEL_WIDTH  = mpfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = mpfb_pkg::PANEL_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  mpfb_pkg::cmd_t                 cmd_in,
    output logic                           pop,
    output logic                           clearing,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_data
    output logic [mpfb_pkg::DATA_W-1:0]    m_tdata
);

    localparam int PAGE_COUNT =
        (PANEL_HEIGHT + mpfb_pkg::ROWS_PER_PAGE - 1) / mpfb_pkg::ROWS_PER_PAGE;
    localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [mpfb_pkg::Y_W:0]      Y_LIM = (mpfb_pkg::Y_W + 1)'(PANEL_HEIGHT);
    localparam logic [mpfb_pkg::X_W-1:0]    X_MAX = mpfb_pkg::X_W'(PANEL_WIDTH - 1);
    localparam logic [mpfb_pkg::PAGE_W-1:0] P_MAX = mpfb_pkg::PAGE_W'(PAGE_COUNT - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_WALK  = 6'b000100,
        S_READ  = 6'b001000,
        S_FLUSH = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    mpfb_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [mpfb_pkg::X_W-1:0]        x_reg, x_next;
    logic [mpfb_pkg::PAGE_W-1:0]     page_reg, page_next;
    logic [AW-1:0]                   clr_cnt_reg, clr_cnt_next;

    logic [mpfb_pkg::DATA_W-1:0]     mem [STORE_BYTES];
    logic [mpfb_pkg::DATA_W-1:0]     rd_data_reg;
    logic                            mem_re, mem_we;
    logic [AW-1:0]                   mem_raddr, mem_waddr;
    logic [mpfb_pkg::DATA_W-1:0]     mem_wdata;

    logic                            wr_valid_reg, wr_valid_next;
    logic [AW-1:0]                   wr_addr_reg;
    logic [mpfb_pkg::DATA_W-1:0]     wr_mask_reg;
    logic                            wr_set_reg;

    logic                            out_valid_reg, out_valid_next;
    logic [mpfb_pkg::DATA_W-1:0]     out_data_reg;
    logic                            load_out;
    logic                            read_in_range;
    logic [AW-1:0]                   walk_addr;
    logic [mpfb_pkg::DATA_W-1:0]     walk_mask;
    logic                            edge_col;

    assign clearing      = (state_reg == S_CLEAR);
    assign pop           = (state_reg == S_IDLE) && cmd_valid;
    assign read_in_range = (32'(cmd_reg.addr) < STORE_BYTES);
    assign load_out      = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

    // Byte address and pixel mask of the current walk position
    assign walk_addr = AW'(32'(page_reg) * PANEL_WIDTH + 32'(x_reg));
    assign edge_col  = (x_reg == cmd_reg.x_lo) || (x_reg == cmd_reg.x_hi);

    always_comb
    begin
        logic [mpfb_pkg::Y_W-1:0] y;
        walk_mask = '0;
        for (int i = 0; i < mpfb_pkg::ROWS_PER_PAGE; i++)
        begin
            y = {page_reg, 3'(i)};
            if (cmd_reg.action == mpfb_pkg::ACT_OUTLINE)
            begin
                walk_mask[i] = (y == cmd_reg.y_lo) || (y == cmd_reg.y_hi) ||
                               (edge_col && (y >= cmd_reg.y_lo) && (y <= cmd_reg.y_hi));
            end
            else
            begin
                walk_mask[i] = (y >= cmd_reg.y_lo) && (y < cmd_reg.y_hi);
            end
            walk_mask[i] = walk_mask[i] && ({1'b0, y} < Y_LIM);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        x_next        = x_reg;
        page_next     = page_reg;
        clr_cnt_next  = clr_cnt_reg;
        wr_valid_next = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = walk_addr;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next  = cmd_in;
                    x_next    = cmd_in.x_lo;
                    page_next = cmd_in.page_first;
                    if (cmd_in.action == mpfb_pkg::ACT_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (cmd_in.empty)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                mem_re        = 1'b1;
                wr_valid_next = 1'b1;
                if (page_reg == cmd_reg.page_last)
                begin
                    page_next = cmd_reg.page_first;
                    if (x_reg == cmd_reg.x_last)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        x_next = x_reg + mpfb_pkg::X_W'(1);
                    end
                end
                else
                begin
                    page_next = page_reg + mpfb_pkg::PAGE_W'(1);
                end
            end
            S_READ:
            begin
                mem_re     = read_in_range;
                mem_raddr  = AW'(cmd_reg.addr);
                state_next = S_DONE;
            end
            S_FLUSH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            wr_valid_reg  <= wr_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        x_reg       <= x_next;
        page_reg    <= page_next;
        wr_addr_reg <= walk_addr;
        wr_mask_reg <= walk_mask;
        wr_set_reg  <= (cmd_reg.action != mpfb_pkg::ACT_CLEAR);
        if (load_out)
        begin
            out_data_reg <= (cmd_reg.action == mpfb_pkg::ACT_READ && read_in_range)
                            ? rd_data_reg : '0;
        end
    end

    // Write port: clearing pass or the modify half of a walk step
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = wr_set_reg ? (rd_data_reg | wr_mask_reg) : (rd_data_reg & ~wr_mask_reg);
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (wr_valid_reg)
        begin
            mem_we = 1'b1;
        end
    end

    // Frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // A pending write belongs to the walk or its flush cycle
    a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid_reg |-> (state_reg == S_WALK || state_reg == S_FLUSH))
        else $error("store write outside a walk");

    // Walk position stays on the panel
    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (x_reg <= X_MAX && page_reg <= P_MAX))
        else $error("walk left the panel");

    // No command is taken before the clearing pass has finished
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !pop)
        else $error("command taken during clearing pass");

endmodule
